[sv/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg
// Types and constants shared by the awning threshold controller.
// ----------------------------------------------------------------------------
package atc_pkg;

  typedef enum logic [1:0] {
    CMD_EVALUATE = 2'd0,
    CMD_MANUAL_OUT = 2'd1,
    CMD_MANUAL_IN = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TRAVEL_IDLE = 2'd0,
    TRAVEL_OUT = 2'd1,
    TRAVEL_IN = 2'd2
  } travel_t;

  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_TEMP = 3'd1;
  localparam logic [2:0] MODE_LIGHT = 3'd2;
  localparam logic [2:0] MODE_EITHER = 3'd3;
  localparam logic [2:0] MODE_BOTH = 3'd4;

  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_EXT_DIST = 3'd0;
  localparam logic [2:0] REG_RET_DIST = 3'd1;
  localparam logic [2:0] REG_TEMP_THR = 3'd2;
  localparam logic [2:0] REG_LIGHT_THR = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  localparam logic [7:0] EXT_DIST_RST = 8'd100;
  localparam logic [7:0] RET_DIST_RST = 8'd5;
  localparam logic [7:0] TEMP_THR_RST = 8'd24;
  localparam logic [7:0] LIGHT_THR_RST = 8'd90;

  typedef struct packed {
    logic [7:0] ext_dist;
    logic [7:0] ret_dist;
    logic signed [7:0] temp_thr;
    logic [7:0] light_thr;
    logic [2:0] mode;
    logic mode_wr;
  } cfg_t;

  typedef struct packed {
    logic step_level;
    logic indicator;
    logic position;
    logic [1:0] travel;
    logic save_position;
    logic [2:0] effective_mode;
  } res_t;

endpackage

[sv/awning_threshold_controller_top.sv]
// ----------------------------------------------------------------------------
// awning_threshold_controller_top
// Path: an accepted item is registered in the stage-1 regs, and the result reg
// loads from them when the output is free. Throughput: one item per cycle
// while out_ready is high; the state update sits between the two regs.
// Stalls on the output back up through ready one stage at a time.
// Reset: synchronous active-low rst_n; retracted, idle, no override,
// registers at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module awning_threshold_controller_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_avg_light,
  input  logic signed [9:0] in_avg_temp,
  input  logic [15:0] in_distance,
  output logic out_valid,
  input  logic out_ready,
  output logic out_step_level,
  output logic out_indicator,
  output logic out_position,
  output logic [1:0] out_travel,
  output logic out_save_position,
  output logic [2:0] out_effective_mode,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [atc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  atc_pkg::cfg_t cfg;
  atc_pkg::res_t res;
  atc_pkg::res_t res_r;
  logic s1_valid_r;
  atc_pkg::cmd_t s1_cmd_r;
  logic [6:0] s1_light_r;
  logic signed [9:0] s1_temp_r;
  logic [15:0] s1_dist_r;
  logic out_valid_r;
  logic go;

  atc_cfg_regs u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  assign go = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= atc_pkg::cmd_t'(in_command);
      s1_light_r <= in_avg_light;
      s1_temp_r <= in_avg_temp;
      s1_dist_r <= in_distance;
    end
  end

  atc_core u_core (
    .clk(clk),
    .rst_n(rst_n),
    .go(go),
    .command(s1_cmd_r),
    .avg_light(s1_light_r),
    .avg_temp(s1_temp_r),
    .distance(s1_dist_r),
    .cfg(cfg),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_step_level = res_r.step_level;
  assign out_indicator = res_r.indicator;
  assign out_position = res_r.position;
  assign out_travel = res_r.travel;
  assign out_save_position = res_r.save_position;
  assign out_effective_mode = res_r.effective_mode;

endmodule

[sv/atc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// atc_cfg_regs
// APB register file: distance limits, thresholds and mode select.
// ----------------------------------------------------------------------------
module atc_cfg_regs (
  input  logic clk,
  input  logic rst_n,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [atc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output atc_pkg::cfg_t cfg
);

  logic [7:0] ext_dist_r;
  logic [7:0] ret_dist_r;
  logic [7:0] temp_thr_r;
  logic [7:0] light_thr_r;
  logic [2:0] mode_r;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = paddr[atc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_dist_r <= atc_pkg::EXT_DIST_RST;
      ret_dist_r <= atc_pkg::RET_DIST_RST;
      temp_thr_r <= atc_pkg::TEMP_THR_RST;
      light_thr_r <= atc_pkg::LIGHT_THR_RST;
      mode_r <= atc_pkg::MODE_OFF;
    end else if (wr_en) begin
      case (idx)
        atc_pkg::REG_EXT_DIST: ext_dist_r <= pwdata[7:0];
        atc_pkg::REG_RET_DIST: ret_dist_r <= pwdata[7:0];
        atc_pkg::REG_TEMP_THR: temp_thr_r <= pwdata[7:0];
        atc_pkg::REG_LIGHT_THR: light_thr_r <= pwdata[7:0];
        atc_pkg::REG_MODE: mode_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      atc_pkg::REG_EXT_DIST: prdata = {24'd0, ext_dist_r};
      atc_pkg::REG_RET_DIST: prdata = {24'd0, ret_dist_r};
      atc_pkg::REG_TEMP_THR: prdata = {24'd0, temp_thr_r};
      atc_pkg::REG_LIGHT_THR: prdata = {24'd0, light_thr_r};
      atc_pkg::REG_MODE: prdata = {29'd0, mode_r};
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.ext_dist = ext_dist_r;
    cfg.ret_dist = ret_dist_r;
    cfg.temp_thr = temp_thr_r;
    cfg.light_thr = light_thr_r;
    cfg.mode = mode_r;
    cfg.mode_wr = wr_en && (idx == atc_pkg::REG_MODE);
  end

endmodule

[sv/atc_core.sv]
// ----------------------------------------------------------------------------
// atc_core
// Awning state and the per-item decision logic.
// ----------------------------------------------------------------------------
module atc_core (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  atc_pkg::cmd_t command,
  input  logic [6:0] avg_light,
  input  logic signed [9:0] avg_temp,
  input  logic [15:0] distance,
  input  atc_pkg::cfg_t cfg,
  output atc_pkg::res_t res
);

  logic position_r, position_nxt;
  atc_pkg::travel_t travel_r, travel_nxt;
  logic override_r, override_nxt;
  logic step_r, step_nxt;
  logic indicator_r, indicator_nxt;
  logic save;
  logic [2:0] mode_cur;
  logic [2:0] mode_after;
  logic lg, ll, tg, tl;
  logic out_ok, in_ok;
  logic do_ext, do_ret;
  logic signed [9:0] tthr;

  assign mode_cur = (override_r || cfg.mode > atc_pkg::MODE_BOTH) ? atc_pkg::MODE_OFF
                                                                  : cfg.mode;
  assign tthr = 10'(cfg.temp_thr);
  assign lg = {1'b0, avg_light} > cfg.light_thr;
  assign ll = {1'b0, avg_light} < cfg.light_thr;
  assign tg = avg_temp > tthr;
  assign tl = avg_temp < tthr;

  always_comb begin
    out_ok = 1'b0;
    in_ok = 1'b0;
    case (mode_cur)
      atc_pkg::MODE_TEMP: begin
        out_ok = tg;
        in_ok = tl;
      end
      atc_pkg::MODE_LIGHT: begin
        out_ok = lg;
        in_ok = ll;
      end
      atc_pkg::MODE_EITHER: begin
        out_ok = lg | tg;
        in_ok = ll & tl;
      end
      atc_pkg::MODE_BOTH: begin
        out_ok = lg & tg;
        in_ok = ll | tl;
      end
      default: ;
    endcase
  end

  always_comb begin
    position_nxt = position_r;
    travel_nxt = travel_r;
    override_nxt = override_r;
    step_nxt = step_r;
    indicator_nxt = indicator_r;
    save = 1'b0;
    do_ext = 1'b0;
    do_ret = 1'b0;
    case (command)
      atc_pkg::CMD_EVALUATE: begin
        do_ext = !position_r && out_ok;
        do_ret = position_r && in_ok;
      end
      atc_pkg::CMD_MANUAL_OUT: begin
        override_nxt = 1'b1;
        do_ext = 1'b1;
      end
      atc_pkg::CMD_MANUAL_IN: begin
        override_nxt = 1'b1;
        do_ret = 1'b1;
      end
      atc_pkg::CMD_TICK: begin
        if (travel_r == atc_pkg::TRAVEL_OUT) begin
          step_nxt = ~step_r;
          if (distance >= {8'd0, cfg.ext_dist}) begin
            travel_nxt = atc_pkg::TRAVEL_IDLE;
            step_nxt = 1'b0;
            indicator_nxt = 1'b1;
            position_nxt = 1'b1;
            save = 1'b1;
          end
        end else if (travel_r == atc_pkg::TRAVEL_IN) begin
          step_nxt = ~step_r;
          if (distance <= {8'd0, cfg.ret_dist}) begin
            travel_nxt = atc_pkg::TRAVEL_IDLE;
            step_nxt = 1'b0;
            indicator_nxt = 1'b0;
            position_nxt = 1'b0;
            save = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (do_ext && travel_r != atc_pkg::TRAVEL_OUT) begin
      travel_nxt = atc_pkg::TRAVEL_OUT;
      step_nxt = 1'b0;
      indicator_nxt = 1'b1;
    end
    if (do_ret && travel_r != atc_pkg::TRAVEL_IN) begin
      travel_nxt = atc_pkg::TRAVEL_IN;
      step_nxt = 1'b0;
      indicator_nxt = 1'b0;
    end
  end

  assign mode_after = (override_nxt || cfg.mode > atc_pkg::MODE_BOTH) ? atc_pkg::MODE_OFF
                                                                      : cfg.mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= 1'b0;
      travel_r <= atc_pkg::TRAVEL_IDLE;
      override_r <= 1'b0;
      step_r <= 1'b0;
      indicator_r <= 1'b0;
    end else begin
      if (go) begin
        position_r <= position_nxt;
        travel_r <= travel_nxt;
        step_r <= step_nxt;
        indicator_r <= indicator_nxt;
      end
      if (cfg.mode_wr) begin
        override_r <= 1'b0;
      end else if (go) begin
        override_r <= override_nxt;
      end
    end
  end

  always_comb begin
    res.step_level = step_nxt;
    res.indicator = indicator_nxt;
    res.position = position_nxt;
    res.travel = travel_nxt;
    res.save_position = save;
    res.effective_mode = mode_after;
  end

endmodule

[verif/tb_awning_threshold_controller_top.sv]
// ----------------------------------------------------------------------------
// tb_awning_threshold_controller_top
// Drives commands into the awning controller through its valid/ready input
// channel and sets up thresholds and modes through the APB-style port. Every
// accepted item advances an in-bench model of the awning (position, travel,
// override, step, lamp). Each result is then compared field by field against
// the oldest predicted status. A short directed run is followed by twelve
// randomized phases.
// ----------------------------------------------------------------------------
module tb_awning_threshold_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  class awning_sb;
    logic [7:0] ext_dist;
    logic [7:0] ret_dist;
    logic [7:0] light_thr;
    logic signed [7:0] temp_thr;
    logic [2:0] mode_sel;
    bit position_q;
    bit override_q;
    bit step_q;
    bit lamp_q;
    atc_pkg::travel_t travel_q;
    atc_pkg::res_t awning_status_q[$];
    int errors;

    function void reset_state();
      ext_dist = atc_pkg::EXT_DIST_RST;
      ret_dist = atc_pkg::RET_DIST_RST;
      temp_thr = atc_pkg::TEMP_THR_RST;
      light_thr = atc_pkg::LIGHT_THR_RST;
      mode_sel = atc_pkg::MODE_OFF;
      position_q = 1'b0;
      override_q = 1'b0;
      step_q = 1'b0;
      lamp_q = 1'b0;
      travel_q = atc_pkg::TRAVEL_IDLE;
      awning_status_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        atc_pkg::REG_EXT_DIST: ext_dist = val[7:0];
        atc_pkg::REG_RET_DIST: ret_dist = val[7:0];
        atc_pkg::REG_TEMP_THR: temp_thr = val[7:0];
        atc_pkg::REG_LIGHT_THR: light_thr = val[7:0];
        atc_pkg::REG_MODE: begin
          mode_sel = val[2:0];
          override_q = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function logic [2:0] mode_in_force();
      if (override_q || mode_sel > atc_pkg::MODE_BOTH) return atc_pkg::MODE_OFF;
      return mode_sel;
    endfunction

    function void begin_travel(atc_pkg::travel_t dir);
      if (travel_q != dir) begin
        travel_q = dir;
        step_q = 1'b0;
        lamp_q = (dir == atc_pkg::TRAVEL_OUT);
      end
    endfunction

    function int pending();
      return awning_status_q.size();
    endfunction

    function void advance_awning(atc_pkg::cmd_t cmd, logic [6:0] light,
                                 logic signed [9:0] temp, logic [15:0] dist_cm);
      int t;
      int tt;
      int l;
      int lt;
      bit go_out;
      bit go_in;
      bit save;
      atc_pkg::res_t r;
      t = temp;
      tt = temp_thr;
      l = light;
      lt = light_thr;
      go_out = 1'b0;
      go_in = 1'b0;
      save = 1'b0;
      case (cmd)
        atc_pkg::CMD_EVALUATE: begin
          case (mode_in_force())
            atc_pkg::MODE_TEMP: begin
              go_out = t > tt;
              go_in = t < tt;
            end
            atc_pkg::MODE_LIGHT: begin
              go_out = l > lt;
              go_in = l < lt;
            end
            atc_pkg::MODE_EITHER: begin
              go_out = (l > lt) || (t > tt);
              go_in = (l < lt) && (t < tt);
            end
            atc_pkg::MODE_BOTH: begin
              go_out = (l > lt) && (t > tt);
              go_in = (l < lt) || (t < tt);
            end
            default: ;
          endcase
          if (!position_q) begin
            if (go_out) begin_travel(atc_pkg::TRAVEL_OUT);
          end else begin
            if (go_in) begin_travel(atc_pkg::TRAVEL_IN);
          end
        end
        atc_pkg::CMD_MANUAL_OUT: begin
          override_q = 1'b1;
          begin_travel(atc_pkg::TRAVEL_OUT);
        end
        atc_pkg::CMD_MANUAL_IN: begin
          override_q = 1'b1;
          begin_travel(atc_pkg::TRAVEL_IN);
        end
        default: begin
          if (travel_q == atc_pkg::TRAVEL_OUT) begin
            step_q = ~step_q;
            if (dist_cm >= {8'd0, ext_dist}) begin
              travel_q = atc_pkg::TRAVEL_IDLE;
              step_q = 1'b0;
              lamp_q = 1'b1;
              position_q = 1'b1;
              save = 1'b1;
            end
          end else if (travel_q == atc_pkg::TRAVEL_IN) begin
            step_q = ~step_q;
            if (dist_cm <= {8'd0, ret_dist}) begin
              travel_q = atc_pkg::TRAVEL_IDLE;
              step_q = 1'b0;
              lamp_q = 1'b0;
              position_q = 1'b0;
              save = 1'b1;
            end
          end
        end
      endcase
      r.step_level = step_q;
      r.indicator = lamp_q;
      r.position = position_q;
      r.travel = travel_q;
      r.save_position = save;
      r.effective_mode = mode_in_force();
      awning_status_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void compare_status(logic step, logic lamp, logic pos, logic [1:0] trav,
                                 logic save, logic [2:0] mode);
      atc_pkg::res_t e;
      if (awning_status_q.size() == 0) begin
        $error("result with no pending item");
        errors++;
        return;
      end
      e = awning_status_q.pop_front();
      field_check("step_level", 32'(e.step_level), 32'(step));
      field_check("indicator", 32'(e.indicator), 32'(lamp));
      field_check("position", 32'(e.position), 32'(pos));
      field_check("travel", 32'(e.travel), 32'(trav));
      field_check("save_position", 32'(e.save_position), 32'(save));
      field_check("effective_mode", 32'(e.effective_mode), 32'(mode));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic [6:0] in_avg_light;
  logic signed [9:0] in_avg_temp;
  logic [15:0] in_distance;
  logic out_valid;
  logic out_ready;
  logic out_step_level;
  logic out_indicator;
  logic out_position;
  logic [1:0] out_travel;
  logic out_save_position;
  logic [2:0] out_effective_mode;
  logic psel;
  logic penable;
  logic pwrite;
  logic [atc_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  awning_sb sb = new;
  bit in_no_gap = 1'b0;
  bit out_no_stall = 1'b0;
  bit hold_request = 1'b0;

  awning_threshold_controller_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_avg_light(in_avg_light),
    .in_avg_temp(in_avg_temp),
    .in_distance(in_distance),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_step_level(out_step_level),
    .out_indicator(out_indicator),
    .out_position(out_position),
    .out_travel(out_travel),
    .out_save_position(out_save_position),
    .out_effective_mode(out_effective_mode),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready)
        sb.advance_awning(atc_pkg::cmd_t'(in_command), in_avg_light, in_avg_temp,
                          in_distance);
      if (out_valid && out_ready)
        sb.compare_status(out_step_level, out_indicator, out_position, out_travel,
                          out_save_position, out_effective_mode);
    end
  end

  // result side: per-item stall, or one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        stall = 48;
        hold_request = 1'b0;
      end else if (out_no_stall) begin
        stall = 0;
      end else begin
        stall = $urandom_range(3, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    #2ms;
    $display("tb_awning_threshold_controller_top: errors");
    $finish;
  end

  function automatic int near(int v, int lo, int hi);
    int x;
    x = v + int'($urandom_range(2, 0)) - 1;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  task automatic send_item(atc_pkg::cmd_t cmd, logic [6:0] light, logic signed [9:0] temp,
                           logic [15:0] dist_cm);
    int gap;
    gap = in_no_gap ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_avg_light <= light;
    in_avg_temp <= temp;
    in_distance <= dist_cm;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    int light;
    int temp;
    int dist_cm;
    atc_pkg::cmd_t cmd;
    r = $urandom_range(99, 0);
    if (r < 45) cmd = atc_pkg::CMD_TICK;
    else if (r < 85) cmd = atc_pkg::CMD_EVALUATE;
    else if (r < 93) cmd = atc_pkg::CMD_MANUAL_OUT;
    else cmd = atc_pkg::CMD_MANUAL_IN;
    if ($urandom_range(1, 0)) light = $urandom_range(127, 0);
    else light = near(sb.light_thr, 0, 127);
    if ($urandom_range(1, 0)) temp = int'($urandom_range(639, 0)) - 128;
    else temp = near(sb.temp_thr, -128, 511);
    case ($urandom_range(9, 0))
      0: dist_cm = $urandom_range(65535, 0);
      1, 2: dist_cm = near(sb.ext_dist, 0, 65535);
      3, 4: dist_cm = near(sb.ret_dist, 0, 65535);
      default: dist_cm = $urandom_range(sb.ext_dist, sb.ret_dist);
    endcase
    send_item(cmd, light[6:0], temp[9:0], dist_cm[15:0]);
  endtask

  task automatic set_phase(int p);
    int ext;
    int ret;
    int tthr;
    int lthr;
    int mode;
    case (p)
      1: begin
        ext = 255;
        ret = 0;
        tthr = -128;
        lthr = 0;
      end
      2: begin
        ext = 0;
        ret = 255;
        tthr = 127;
        lthr = 255;
      end
      default: begin
        ext = $urandom_range(255, 40);
        ret = $urandom_range(30, 0);
        tthr = int'($urandom_range(50, 0)) - 5;
        lthr = $urandom_range(127, 0);
      end
    endcase
    mode = (p < 8) ? (p + 1) % 8 : p - 7;
    wait_drained();
    cfg_write(atc_pkg::REG_EXT_DIST, ext);
    cfg_write(atc_pkg::REG_RET_DIST, ret);
    cfg_write(atc_pkg::REG_TEMP_THR, {24'd0, 8'(tthr)});
    cfg_write(atc_pkg::REG_LIGHT_THR, lthr);
    cfg_write(atc_pkg::REG_MODE, mode);
    in_no_gap = (p % 3 == 0);
    out_no_stall = (p % 4 == 1);
    if (p == 3) hold_request = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = atc_pkg::CMD_EVALUATE;
    in_avg_light = '0;
    in_avg_temp = '0;
    in_distance = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sb.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // mode off: idle tick, evaluate does nothing
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd0);
    send_item(atc_pkg::CMD_EVALUATE, 7'd127, 10'sd511, 16'd0);
    wait_drained();
    cfg_write(atc_pkg::REG_MODE, 32'(atc_pkg::MODE_TEMP));
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, 10'sd24, 16'd0);
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, 10'sd25, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd99);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd100);
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, 10'sd24, 16'd0);
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, -10'sd128, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'hFFFF);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd5);
    // manual travel, repeat, reversal, and retract toward where it already is
    send_item(atc_pkg::CMD_MANUAL_OUT, 7'd0, 10'sd0, 16'd0);
    send_item(atc_pkg::CMD_MANUAL_OUT, 7'd0, 10'sd0, 16'd0);
    send_item(atc_pkg::CMD_MANUAL_IN, 7'd0, 10'sd0, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd0);
    wait_drained();
    // unused mode value acts as off
    cfg_write(atc_pkg::REG_MODE, 32'd7);
    send_item(atc_pkg::CMD_EVALUATE, 7'd127, 10'sd511, 16'd0);
    wait_drained();
    cfg_write(atc_pkg::REG_MODE, 32'(atc_pkg::MODE_BOTH));
    send_item(atc_pkg::CMD_EVALUATE, 7'd91, 10'sd25, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'hFFFF);
    send_item(atc_pkg::CMD_EVALUATE, 7'd89, 10'sd511, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd6);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd5);
    wait_drained();
    cfg_write(atc_pkg::REG_MODE, 32'(atc_pkg::MODE_EITHER));
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, -10'sd128, 16'd0);
    send_item(atc_pkg::CMD_EVALUATE, 7'd91, 10'sd0, 16'd0);
    send_item(atc_pkg::CMD_TICK, 7'd0, 10'sd0, 16'd100);
    send_item(atc_pkg::CMD_EVALUATE, 7'd0, -10'sd128, 16'd0);
    send_item(atc_pkg::CMD_MANUAL_IN, 7'd0, 10'sd0, 16'd0);

    for (int p = 0; p < 12; p++) begin
      set_phase(p);
      for (int i = 0; i < 53; i++) begin
        if (p == 6 && i == 26) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_awning_threshold_controller_top: clean");
    end else begin
      $display("tb_awning_threshold_controller_top: errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/atc_pkg.sv
sv/atc_cfg_regs.sv
sv/atc_core.sv
sv/awning_threshold_controller_top.sv
verif/tb_awning_threshold_controller_top.sv
